// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge out of reset
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(label, prop, msg)

`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/plos_pkg.sv -----
// ----------------------------------------------------------------------------
// plos_pkg
// Types, constants and codes shared by the weight matrix scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package plos_pkg;

    // Window and alphabet sizes
    localparam int MAX_LEN  = 32;
    localparam int ALPHABET = 4;

    localparam int LEN_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SYM_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CNT_W    = 6;
    localparam int CMP_W    = ((LEN_W + 1) > CNT_W) ? (LEN_W + 1) : CNT_W;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int POS_W    = 5;
    localparam int BASE_W   = 5;
    localparam int WEIGHT_W = 16;
    localparam int SCORE_W  = 22;
    localparam int STATUS_W = 2;
    localparam int TERM_W   = WEIGHT_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int MODE_W     = 2;

    localparam logic [CNT_W-1:0]  COUNT_TOP        = '1;
    localparam logic [CNT_W-1:0]  WORD_LENGTH_INIT = CNT_W'(8);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_WORD = 2'd0,
        REQ_LOAD_BG   = 2'd1,
        REQ_SCAN      = 2'd2,
        REQ_RESTART   = 2'd3
    } req_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_WORD       = 2'd0,
        MODE_LOG_ODDS   = 2'd1,
        MODE_BACKGROUND = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FULL     = 2'd0,
        ST_VALID        = 2'd1,
        ST_INVALID_BASE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_LENGTH = 2'd0,
        REG_SCORE_MODE  = 2'd1
    } reg_t;

    // Input transaction
    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic [POS_W-1:0]           position;
        logic [BASE_W-1:0]          base_index;
        logic signed [WEIGHT_W-1:0] weight;
    } plos_in_t;

    // Result transaction
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [STATUS_W-1:0]       status;
    } plos_out_t;

    // Per-cell control
    typedef struct packed {
        logic clear;
        logic shift;
        logic wr_word;
    } cell_ctrl_t;

    // Broadcast to every cell
    typedef struct packed {
        logic                       base_ok;
        logic [SYM_W-1:0]           sym;
        logic [MODE_W-1:0]          mode;
        logic signed [WEIGHT_W-1:0] bg_weight;
        logic signed [WEIGHT_W-1:0] wr_weight;
    } cell_bus_t;

endpackage

`default_nettype wire

// ----- rtl/plos_cell.sv -----
// ----------------------------------------------------------------------------
// plos_cell
// One window position: word weights for that position and one partial sum.
// Adds its term to the partial sum and hands the result to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module plos_cell (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire plos_pkg::cell_ctrl_t                   ctrl,
    input  wire plos_pkg::cell_bus_t                    bus,
    input  wire logic signed [plos_pkg::SCORE_W-1:0]    ps_in,
    output logic signed [plos_pkg::SCORE_W-1:0]         sum_out
);

    logic signed [plos_pkg::WEIGHT_W-1:0] word_weight_reg [plos_pkg::ALPHABET];
    logic signed [plos_pkg::SCORE_W-1:0]  ps_reg;
    logic signed [plos_pkg::SCORE_W-1:0]  ps_next;
    logic signed [plos_pkg::WEIGHT_W-1:0] word_weight;
    logic signed [plos_pkg::TERM_W-1:0]   term;
    logic signed [plos_pkg::SCORE_W:0]    wide_sum;

    // Store word weights for this position
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_word)
        begin
            word_weight_reg[bus.sym] <= bus.wr_weight;
        end
    end

    // Pick the term for the current base and mode
    always_comb
    begin
        word_weight = word_weight_reg[bus.sym];
        unique case (bus.mode)
            plos_pkg::MODE_WORD:
                term = plos_pkg::TERM_W'(word_weight);
            plos_pkg::MODE_LOG_ODDS:
                term = plos_pkg::TERM_W'(word_weight) - plos_pkg::TERM_W'(bus.bg_weight);
            default:
                term = plos_pkg::TERM_W'(bus.bg_weight);
        endcase
        if (!bus.base_ok)
        begin
            term = '0;
        end
    end

    // Add and saturate to the score range
    always_comb
    begin
        wide_sum = (plos_pkg::SCORE_W + 1)'(ps_reg) + (plos_pkg::SCORE_W + 1)'(term);
        if (wide_sum[plos_pkg::SCORE_W] != wide_sum[plos_pkg::SCORE_W-1])
        begin
            sum_out = wide_sum[plos_pkg::SCORE_W]
                    ? {1'b1, {(plos_pkg::SCORE_W-1){1'b0}}}
                    : {1'b0, {(plos_pkg::SCORE_W-1){1'b1}}};
        end
        else
        begin
            sum_out = wide_sum[plos_pkg::SCORE_W-1:0];
        end
    end

    // Take the upstream sum on a scan, drop it on restart
    always_comb
    begin
        ps_next = ps_reg;
        if (ctrl.clear)
        begin
            ps_next = '0;
        end
        else if (ctrl.shift)
        begin
            ps_next = ps_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg <= '0;
        end
        else
        begin
            ps_reg <= ps_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/plos_out_skid.sv -----
// ----------------------------------------------------------------------------
// plos_out_skid
// Output register with a skid stage: takes a result while the previous one
// waits, and asserts full once both slots hold a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module plos_out_skid (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire plos_pkg::plos_out_t  push_data,
    output logic                      full,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output plos_pkg::plos_out_t       out_data
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    plos_pkg::plos_out_t  out_data_reg;
    plos_pkg::plos_out_t  out_data_next;
    plos_pkg::plos_out_t  skid_data_reg;
    plos_pkg::plos_out_t  skid_data_next;
    logic                 slot_free;

    // Advance the skid entry into the output slot when it frees
    always_comb
    begin
        slot_free       = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (slot_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/pwm_log_odds_scanner.sv -----
// ----------------------------------------------------------------------------
// pwm_log_odds_scanner
// Sliding-window position weight matrix scorer built as a row of cells.
// ----------------------------------------------------------------------------
// A new transaction is taken each cycle while the input is not stalled, and
// each scan result is registered in the output register or the skid stage.
// The rate is set by the row of adder cells: each cell holds the weights of
// one window position and one partial sum, and all cells add their term and
// pass the sum to the next cell in the same cycle, so the window ending at
// every base completes as the base arrives. Load transactions fill weights
// and give no result; restart clears the partial sums and counters. Input
// stalls only when both the output register and the skid stage are occupied.
// Weights are Q8.8 log2 values and sums saturate to 22 bits.
`default_nettype none

`include "assert_macros.svh"

module pwm_log_odds_scanner (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire plos_pkg::plos_in_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output plos_pkg::plos_out_t                     out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [plos_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [plos_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [plos_pkg::CNT_W-1:0]            word_length_reg;
    logic [plos_pkg::MODE_W-1:0]           score_mode_reg;
    logic [plos_pkg::CNT_W-1:0]            bases_seen_reg;
    logic [plos_pkg::CNT_W-1:0]            bases_seen_next;
    logic [plos_pkg::CNT_W-1:0]            since_invalid_reg;
    logic [plos_pkg::CNT_W-1:0]            since_invalid_next;
    logic signed [plos_pkg::WEIGHT_W-1:0]  bg_weight_reg [plos_pkg::ALPHABET];

    logic                                  in_accept;
    logic                                  scan;
    logic                                  restart;
    logic                                  load_word;
    logic                                  load_bg;
    logic                                  base_ok;
    logic [plos_pkg::SYM_W-1:0]            sym;
    logic [plos_pkg::LEN_W-1:0]            len_m1;
    logic [plos_pkg::CMP_W-1:0]            len_full;
    logic signed [plos_pkg::SCORE_W-1:0]   done;
    plos_pkg::plos_out_t                   result;
    plos_pkg::cell_bus_t                   bus;
    plos_pkg::cell_ctrl_t                  ctrl [plos_pkg::MAX_LEN];
    logic signed [plos_pkg::SCORE_W-1:0]   sum_out [plos_pkg::MAX_LEN];

    // Decode the input transaction
    assign in_accept = in_valid && !in_stall;
    assign scan      = in_accept && (in_data.req_type == plos_pkg::REQ_SCAN);
    assign restart   = in_accept && (in_data.req_type == plos_pkg::REQ_RESTART);
    assign load_word = in_accept && (in_data.req_type == plos_pkg::REQ_LOAD_WORD);
    assign load_bg   = in_accept && (in_data.req_type == plos_pkg::REQ_LOAD_BG);
    assign base_ok   = in_data.base_index < plos_pkg::BASE_W'(plos_pkg::ALPHABET);
    assign sym       = in_data.base_index[plos_pkg::SYM_W-1:0];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= plos_pkg::WORD_LENGTH_INIT;
            score_mode_reg  <= plos_pkg::MODE_LOG_ODDS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                plos_pkg::REG_WORD_LENGTH:
                    word_length_reg <= cfg_data[plos_pkg::CNT_W-1:0];
                plos_pkg::REG_SCORE_MODE:
                    score_mode_reg <= cfg_data[plos_pkg::MODE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Clamp the window length to one through the row length
    always_comb
    begin
        if (word_length_reg == '0)
        begin
            len_m1 = '0;
        end
        else if ({1'b0, word_length_reg} > (plos_pkg::CNT_W + 1)'(plos_pkg::MAX_LEN))
        begin
            len_m1 = plos_pkg::LEN_W'(plos_pkg::MAX_LEN - 1);
        end
        else
        begin
            len_m1 = plos_pkg::LEN_W'(word_length_reg - 1'b1);
        end
        len_full = plos_pkg::CMP_W'(len_m1) + plos_pkg::CMP_W'(1);
    end

    // Background weights
    always_ff @(posedge clk)
    begin
        if (load_bg && base_ok)
        begin
            bg_weight_reg[sym] <= in_data.weight;
        end
    end

    // Broadcast to the cells
    assign bus.base_ok   = base_ok;
    assign bus.sym       = sym;
    assign bus.mode      = score_mode_reg;
    assign bus.bg_weight = bg_weight_reg[sym];
    assign bus.wr_weight = in_data.weight;

    // Row of cells; cell k holds the partial sum that has taken k bases
    for (genvar k = 0; k < plos_pkg::MAX_LEN; k++)
    begin : g_cell
        logic signed [plos_pkg::SCORE_W-1:0] ps_in;

        assign ctrl[k].clear   = restart;
        assign ctrl[k].shift   = scan && (int'(len_m1) >= k);
        assign ctrl[k].wr_word = load_word && base_ok && (int'(in_data.position) == k);

        if (k == 0)
        begin : g_head
            assign ps_in = '0;
        end
        else
        begin : g_link
            assign ps_in = sum_out[k-1];
        end

        plos_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[k]),
            .bus     (bus),
            .ps_in   (ps_in),
            .sum_out (sum_out[k])
        );
    end

    // Window counters
    always_comb
    begin
        bases_seen_next = bases_seen_reg;
        if (bases_seen_reg != plos_pkg::COUNT_TOP)
        begin
            bases_seen_next = bases_seen_reg + 1'b1;
        end
        since_invalid_next = since_invalid_reg;
        if (!base_ok)
        begin
            since_invalid_next = '0;
        end
        else if (since_invalid_reg != plos_pkg::COUNT_TOP)
        begin
            since_invalid_next = since_invalid_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bases_seen_reg    <= '0;
            since_invalid_reg <= plos_pkg::COUNT_TOP;
        end
        else if (restart)
        begin
            bases_seen_reg    <= '0;
            since_invalid_reg <= plos_pkg::COUNT_TOP;
        end
        else if (scan)
        begin
            bases_seen_reg    <= bases_seen_next;
            since_invalid_reg <= since_invalid_next;
        end
    end

    // Form the result of the window ending at this base
    assign done = sum_out[len_m1];

    always_comb
    begin
        if (plos_pkg::CMP_W'(bases_seen_next) < len_full)
        begin
            result.status = plos_pkg::ST_NOT_FULL;
            result.score  = '0;
        end
        else if (plos_pkg::CMP_W'(since_invalid_next) < len_full)
        begin
            result.status = plos_pkg::ST_INVALID_BASE;
            result.score  = '0;
        end
        else
        begin
            result.status = plos_pkg::ST_VALID;
            result.score  = done;
        end
    end

    // Hold results in the output register and skid stage
    plos_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (scan),
        .push_data (result),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Checks
    `ASSERT_HOLDS(a_stall_has_output, in_stall |-> out_valid, "input stalled with output empty")
    `ASSERT_NEXT(a_no_result_from_load, in_accept && !scan && !out_valid, !out_valid, "result from a non-scan transaction")
    `ASSERT_HOLDS(a_score_zero_unless_valid, (out_valid && out_data.status != plos_pkg::ST_VALID) |-> (out_data.score == '0), "nonzero score on a window without a valid score")
    `ASSERT_NEXT(a_restart_clears, restart, (bases_seen_reg == '0) && (since_invalid_reg == plos_pkg::COUNT_TOP), "restart did not clear the window counters")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weight matrix window scanner. A queue of
// request transactions feeds a bursty driver; every accepted transaction
// updates a scoreboard copy of the weight tables and the row of partial sums,
// and each scan queues its expected window score. A monitor under a varying
// stall pattern checks each result against the oldest expected score.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SCORE_HI      = 2097151;
    localparam int SCORE_LO      = -2097152;
    localparam int BASE_TOP      = (1 << plos_pkg::BASE_W) - 1;
    localparam int POS_TOP       = (1 << plos_pkg::POS_W) - 1;

    // Register indexes and mode value that the package leaves unnamed
    localparam logic [plos_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [plos_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [plos_pkg::MODE_W-1:0]    MODE_SPARE  = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    plos_pkg::plos_in_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    plos_pkg::plos_out_t             out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [plos_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [plos_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Stimulus and scoreboard storage
    plos_pkg::plos_in_t  pending_requests[$];
    plos_pkg::plos_out_t expected_scores[$];
    bit                  hold_off = 1'b0;
    int                  errors   = 0;

    // Scoreboard copy of the block state
    logic signed [plos_pkg::WEIGHT_W-1:0] pos_weight [plos_pkg::MAX_LEN*plos_pkg::ALPHABET];
    logic signed [plos_pkg::WEIGHT_W-1:0] bg_weight  [plos_pkg::ALPHABET];
    int                                   window_sums[plos_pkg::MAX_LEN];
    logic [plos_pkg::CNT_W-1:0]           bases_seen;
    logic [plos_pkg::CNT_W-1:0]           since_invalid;
    logic [plos_pkg::CFG_DATA_W-1:0]      cfg_len;
    logic [plos_pkg::MODE_W-1:0]          cfg_mode;

    // Driver and receiver pacing
    int                  burst_left = 8;
    int                  gap_left   = 0;
    stall_style_t        stall_style = STALL_NONE;
    int                  stall_span  = 0;
    plos_pkg::plos_out_t want;

    pwm_log_odds_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scoreboard arithmetic
    // ------------------------------------------------------------------
    function automatic int sat_score(input int sum);
        if (sum > SCORE_HI)
            return SCORE_HI;
        if (sum < SCORE_LO)
            return SCORE_LO;
        return sum;
    endfunction

    // Term that one base adds at one window position under the current mode
    function automatic int base_term(input int pos,
                                     input logic [plos_pkg::BASE_W-1:0] base,
                                     input bit valid);
        int w;
        int b;
        if (!valid || pos >= plos_pkg::MAX_LEN)
            return 0;
        w = pos_weight[pos*plos_pkg::ALPHABET + base];
        b = bg_weight[base];
        if (cfg_mode == plos_pkg::MODE_WORD)
            return w;
        if (cfg_mode == plos_pkg::MODE_LOG_ODDS)
            return w - b;
        return b;
    endfunction

    function automatic void clear_sums();
        foreach (window_sums[k])
            window_sums[k] = 0;
        bases_seen    = '0;
        since_invalid = plos_pkg::COUNT_TOP;
    endfunction

    // Apply one accepted request; queue the expected score of a scan
    function automatic void track_request(input plos_pkg::plos_in_t req);
        int                  len;
        int                  done;
        bit                  valid;
        plos_pkg::plos_out_t res;
        valid = (req.base_index < plos_pkg::ALPHABET);
        case (req.req_type)
            plos_pkg::REQ_LOAD_WORD:
                if (valid && req.position < plos_pkg::MAX_LEN)
                    pos_weight[req.position*plos_pkg::ALPHABET + req.base_index] = req.weight;
            plos_pkg::REQ_LOAD_BG:
                if (valid)
                    bg_weight[req.base_index] = req.weight;
            plos_pkg::REQ_RESTART:
                clear_sums();
            default:
            begin
                if (cfg_len == 0)
                    len = 1;
                else if (cfg_len > plos_pkg::MAX_LEN)
                    len = plos_pkg::MAX_LEN;
                else
                    len = cfg_len;
                // Shift the row of partial sums by one position
                done = sat_score(window_sums[len-1] + base_term(len-1, req.base_index, valid));
                for (int k = len - 1; k >= 1; k--)
                    window_sums[k] = sat_score(window_sums[k-1] +
                                               base_term(k-1, req.base_index, valid));
                window_sums[0] = 0;
                if (bases_seen < plos_pkg::COUNT_TOP)
                    bases_seen++;
                if (!valid)
                    since_invalid = '0;
                else if (since_invalid < plos_pkg::COUNT_TOP)
                    since_invalid++;
                if (bases_seen < len)
                begin
                    res.status = plos_pkg::ST_NOT_FULL;
                    res.score  = '0;
                end
                else if (since_invalid < len)
                begin
                    res.status = plos_pkg::ST_INVALID_BASE;
                    res.score  = '0;
                end
                else
                begin
                    res.status = plos_pkg::ST_VALID;
                    res.score  = plos_pkg::SCORE_W'(done);
                end
                expected_scores.insert(expected_scores.size(), res);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Configuration shadow
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len  <= plos_pkg::WORD_LENGTH_INIT;
            cfg_mode <= plos_pkg::MODE_LOG_ODDS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                plos_pkg::REG_WORD_LENGTH: cfg_len  <= cfg_data;
                plos_pkg::REG_SCORE_MODE:  cfg_mode <= cfg_data[plos_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps, hold while stalled
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            clear_sums();
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                track_request(in_data);
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0 && !hold_off)
            begin
                in_data  <= pending_requests.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // Start a new burst; some bursts follow with no gap
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            // Check each accepted result against the oldest expected score
            if (out_valid && !out_stall)
            begin
                if (expected_scores.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual score %0d status %0d",
                             $time, out_data.score, out_data.status);
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, out_data.status);
                    end
                    if (out_data.score !== want.score)
                    begin
                        errors++;
                        $display("%0t: score mismatch, expected %0d, actual %0d",
                                 $time, want.score, out_data.score);
                    end
                end
            end
            // Switch stall style now and then
            if (stall_span == 0)
            begin
                stall_style = stall_style_t'($urandom_range(0, 3));
                stall_span  = $urandom_range(50, 300);
            end
            else
                stall_span--;
            case (stall_style)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 7) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                default:      out_stall <= stall_span[2];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input plos_pkg::req_t r, input logic [plos_pkg::POS_W-1:0] pos,
                            input logic [plos_pkg::BASE_W-1:0] base,
                            input logic [plos_pkg::WEIGHT_W-1:0] wt);
        plos_pkg::plos_in_t req;
        req.req_type   = r;
        req.position   = pos;
        req.base_index = base;
        req.weight     = wt;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // Mostly scans of valid bases, with loads, restarts and bad bases mixed in
    task automatic push_random(input int count, input int bad_pct);
        int                            roll;
        logic [plos_pkg::BASE_W-1:0]   base;
        logic [plos_pkg::POS_W-1:0]    pos;
        logic [plos_pkg::WEIGHT_W-1:0] wt;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            pos  = plos_pkg::POS_W'($urandom_range(0, POS_TOP));
            wt   = plos_pkg::WEIGHT_W'($urandom);
            if ($urandom_range(0, 99) < bad_pct)
                base = plos_pkg::BASE_W'($urandom_range(plos_pkg::ALPHABET, BASE_TOP));
            else
                base = plos_pkg::BASE_W'($urandom_range(0, plos_pkg::ALPHABET - 1));
            if (roll < 6)
                push_req(plos_pkg::REQ_LOAD_WORD, pos, base, wt);
            else if (roll < 9)
                push_req(plos_pkg::REQ_LOAD_BG, pos, base, wt);
            else if (roll < 11)
                push_req(plos_pkg::REQ_RESTART, pos, base, wt);
            else
                push_req(plos_pkg::REQ_SCAN, pos, base, wt);
        end
    endtask

    task automatic write_reg(input logic [plos_pkg::CFG_IDX_W-1:0] idx,
                             input logic [plos_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every request is taken and every result has arrived
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_scores.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [plos_pkg::CFG_DATA_W-1:0] len,
                             input logic [plos_pkg::MODE_W-1:0] mode,
                             input bit fresh, input int count, input int bad_pct,
                             input bit pause_mid);
        wait_idle();
        write_reg(plos_pkg::REG_WORD_LENGTH, len);
        write_reg(plos_pkg::REG_SCORE_MODE, plos_pkg::CFG_DATA_W'(mode));
        if (fresh)
            push_req(plos_pkg::REQ_RESTART, plos_pkg::POS_W'($urandom),
                     plos_pkg::BASE_W'($urandom), plos_pkg::WEIGHT_W'($urandom));
        if (pause_mid)
        begin
            push_random(count / 2, bad_pct);
            // Hold the sender with requests still queued until the block drains
            while (pending_requests.size() > count / 8)
                @(negedge clk);
            hold_off = 1'b1;
            do
                @(negedge clk);
            while (in_valid || expected_scores.size() != 0);
            hold_off = 1'b0;
            push_random(count - count / 2, bad_pct);
        end
        else
            push_random(count, bad_pct);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill both weight tables so no scan reads an unwritten weight
        for (int p = 0; p < plos_pkg::MAX_LEN; p++)
            for (int b = 0; b < plos_pkg::ALPHABET; b++)
                push_req(plos_pkg::REQ_LOAD_WORD, plos_pkg::POS_W'(p), plos_pkg::BASE_W'(b),
                         plos_pkg::WEIGHT_W'($urandom));
        for (int b = 0; b < plos_pkg::ALPHABET; b++)
            push_req(plos_pkg::REQ_LOAD_BG, '0, plos_pkg::BASE_W'(b),
                     plos_pkg::WEIGHT_W'($urandom));

        // Directed: weight extremes, ignored loads, window fill, bad bases, restart
        push_req(plos_pkg::REQ_LOAD_WORD, '0, plos_pkg::BASE_W'(0), 16'sh7FFF);
        push_req(plos_pkg::REQ_LOAD_WORD, plos_pkg::POS_W'(POS_TOP),
                 plos_pkg::BASE_W'(plos_pkg::ALPHABET - 1), 16'sh8000);
        push_req(plos_pkg::REQ_LOAD_BG, '0, plos_pkg::BASE_W'(0), 16'sh8000);
        push_req(plos_pkg::REQ_LOAD_BG, '0, plos_pkg::BASE_W'(plos_pkg::ALPHABET - 1),
                 16'sh7FFF);
        push_req(plos_pkg::REQ_LOAD_WORD, plos_pkg::POS_W'(5),
                 plos_pkg::BASE_W'(plos_pkg::ALPHABET), 16'sh1234);
        push_req(plos_pkg::REQ_LOAD_WORD, plos_pkg::POS_W'(POS_TOP),
                 plos_pkg::BASE_W'(BASE_TOP), 16'shFFFF);
        push_req(plos_pkg::REQ_LOAD_BG, '0, plos_pkg::BASE_W'(BASE_TOP), 16'sh8000);
        for (int i = 0; i < 9; i++)
            push_req(plos_pkg::REQ_SCAN, plos_pkg::POS_W'(POS_TOP),
                     plos_pkg::BASE_W'(i % plos_pkg::ALPHABET), 16'shFFFF);
        push_req(plos_pkg::REQ_SCAN, '0, plos_pkg::BASE_W'(plos_pkg::ALPHABET), '0);
        push_req(plos_pkg::REQ_SCAN, '0, plos_pkg::BASE_W'(plos_pkg::ALPHABET - 1), '0);
        push_req(plos_pkg::REQ_SCAN, '0, plos_pkg::BASE_W'(plos_pkg::ALPHABET - 1), '0);
        push_req(plos_pkg::REQ_SCAN, '0, plos_pkg::BASE_W'(BASE_TOP), '0);
        push_req(plos_pkg::REQ_RESTART, '0, '0, '0);
        push_req(plos_pkg::REQ_SCAN, '0, plos_pkg::BASE_W'(0), '0);
        push_req(plos_pkg::REQ_SCAN, '0, plos_pkg::BASE_W'(1), '0);

        // Random phases over several settings, extremes and out-of-range among them
        run_phase(6'd1, plos_pkg::MODE_WORD, 1'b1, 40, 5, 1'b0);
        run_phase(6'd32, plos_pkg::MODE_LOG_ODDS, 1'b1, 60, 1, 1'b0);
        run_phase(6'd0, plos_pkg::MODE_BACKGROUND, 1'b0, 30, 5, 1'b0);
        run_phase(6'd63, MODE_SPARE, 1'b1, 50, 1, 1'b0);
        wait_idle();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, 6'h15);
        run_phase(6'd5, plos_pkg::MODE_LOG_ODDS, 1'b0, 60, 10, 1'b1);
        run_phase(6'd33, plos_pkg::MODE_WORD, 1'b1, 40, 2, 1'b0);
        repeat (3)
            run_phase(plos_pkg::CFG_DATA_W'($urandom_range(1, plos_pkg::MAX_LEN)),
                      plos_pkg::MODE_W'($urandom_range(0, 3)),
                      1'($urandom), 20, 3, 1'b0);

        wait_idle();
        if (errors == 0 && expected_scores.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Bound the run length
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/plos_pkg.sv
rtl/plos_cell.sv
rtl/plos_out_skid.sv
rtl/pwm_log_odds_scanner.sv
bench/tb_top.sv
